// ===== sv/cla_pkg.sv =====
`default_nettype none

package cla_pkg;

  localparam int AXES    = 3;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int OFS_W   = 40;
  localparam int LEN_W   = 17;
  localparam int EB_W    = 5;
  localparam int ND_W    = 2;
  localparam int REG_IDX_W = 3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ORDER   = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_NO_CROP = 2'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ELEM_BYTES = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE0      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE1      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIZE2      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       mul1;
    logic       mul2;
    logic       emit;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic       active;
    logic [1:0] chk_status;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic [ND_W-1:0]   num_dims;
    logic [EB_W-1:0]   elem_bytes;
    logic [SIZE_W-1:0] size0;
    logic [SIZE_W-1:0] size1;
    logic [SIZE_W-1:0] size2;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/cla_ctrl.sv =====
`default_nettype none

module cla_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_cmd,
  input  wire cla_pkg::stat_t stat,
  output cla_pkg::cmd_t      cmd
);

  cla_pkg::state_t state_r, state_nxt;
  logic [1:0]      status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cla_pkg::S_IDLE;
      status_r <= cla_pkg::STAT_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      cla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == cla_pkg::CMD_START) begin
            status_nxt = stat.chk_status;
            state_nxt  = (stat.chk_status == cla_pkg::STAT_OK) ? cla_pkg::S_MUL1
                                                                : cla_pkg::S_EMIT;
          end else if (!stat.active) begin
            status_nxt = cla_pkg::STAT_NO_CROP;
            state_nxt  = cla_pkg::S_EMIT;
          end else begin
            status_nxt = cla_pkg::STAT_OK;
            state_nxt  = cla_pkg::S_MUL1;
          end
        end
      end
      cla_pkg::S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = cla_pkg::S_MUL2;
      end
      cla_pkg::S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = cla_pkg::S_EMIT;
      end
      cla_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = status_r;
          state_nxt       = cla_pkg::S_IDLE;
        end
      end
      default: state_nxt = cla_pkg::S_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != cla_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_mul_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cla_pkg::S_MUL1 |=> state_r == cla_pkg::S_MUL2)
    else $error("multiply stage skipped");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("emit into a full output register");

endmodule

`default_nettype wire

// ===== sv/cla_dp.sv =====
`default_nettype none

module cla_dp #(
  parameter int MAX_DIMS      = 3,
  parameter int MAX_AXIS_SIZE = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cla_pkg::cfg_t  cfg,
  input  wire logic           in_cmd,
  input  wire logic [11:0]    in_lo0,
  input  wire logic [11:0]    in_lo1,
  input  wire logic [11:0]    in_lo2,
  input  wire logic [11:0]    in_hi0,
  input  wire logic [11:0]    in_hi1,
  input  wire logic [11:0]    in_hi2,
  input  wire cla_pkg::cmd_t  cmd,
  output cla_pkg::stat_t      stat,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [39:0]         out_src_offset,
  output logic [39:0]         out_dst_offset,
  output logic [16:0]         out_line_bytes,
  output logic                out_last
);

  localparam int DIMS_CAP = (MAX_DIMS > cla_pkg::AXES) ? cla_pkg::AXES : MAX_DIMS;
  localparam int SIZE_MAX = (2 ** cla_pkg::SIZE_W) - 1;
  localparam int SIZE_CAP = (MAX_AXIS_SIZE > SIZE_MAX) ? SIZE_MAX : MAX_AXIS_SIZE;
  localparam logic [cla_pkg::ND_W-1:0]   DIMS_CAP_V = cla_pkg::ND_W'(DIMS_CAP);
  localparam logic [cla_pkg::SIZE_W-1:0] SIZE_CAP_V = cla_pkg::SIZE_W'(SIZE_CAP);

  logic [cla_pkg::ND_W-1:0]    nd;
  logic [cla_pkg::SIZE_W-1:0]  size_raw [cla_pkg::AXES];
  logic [cla_pkg::SIZE_W-1:0]  size_eff [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] lo_in [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] hi_in [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] lo_m  [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] hi_m  [cla_pkg::AXES];
  logic [1:0]                  chk;

  logic [cla_pkg::COORD_W-1:0] low_r   [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] high_r  [cla_pkg::AXES];
  logic [cla_pkg::COORD_W-1:0] coord1_r, coord2_r;
  logic                        active_r;

  logic [25:0] p1_r, q1_r;
  logic [39:0] p2_r, q2_r;

  logic [12:0] cin1, cin2;
  logic [12:0] osz0, osz1;
  logic [11:0] ext1, ext2;
  logic [26:0] p_sum, q_sum;
  logic [39:0] src_sum;
  logic [44:0] src_prod, dst_prod;
  logic [17:0] len_prod;
  logic        last;
  logic        emit_ok;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [39:0] out_src_r, out_dst_r;
  logic [16:0] out_len_r;
  logic        out_last_r;

  always_comb begin
    nd = (cfg.num_dims == '0) ? cla_pkg::ND_W'(1) : cfg.num_dims;
    if (nd > DIMS_CAP_V) nd = DIMS_CAP_V;
  end

  assign size_raw[0] = cfg.size0;
  assign size_raw[1] = cfg.size1;
  assign size_raw[2] = cfg.size2;
  assign lo_in[0] = in_lo0;
  assign lo_in[1] = in_lo1;
  assign lo_in[2] = in_lo2;
  assign hi_in[0] = in_hi0;
  assign hi_in[1] = in_hi1;
  assign hi_in[2] = in_hi2;

  always_comb begin
    for (int d = 0; d < cla_pkg::AXES; d++) begin
      if (cla_pkg::ND_W'(d) < nd) begin
        size_eff[d] = (size_raw[d] > SIZE_CAP_V) ? SIZE_CAP_V : size_raw[d];
        lo_m[d]     = lo_in[d];
        hi_m[d]     = hi_in[d];
      end else begin
        size_eff[d] = cla_pkg::SIZE_W'(1);
        lo_m[d]     = '0;
        hi_m[d]     = '0;
      end
    end
  end

  // lowest failing axis wins; order check before range check
  always_comb begin
    chk = cla_pkg::STAT_OK;
    for (int d = cla_pkg::AXES - 1; d >= 0; d--) begin
      if (lo_m[d] > hi_m[d]) begin
        chk = cla_pkg::STAT_ORDER;
      end else if ({1'b0, hi_m[d]} >= size_eff[d]) begin
        chk = cla_pkg::STAT_RANGE;
      end
    end
  end

  assign cin1 = {1'b0, low_r[1]} + {1'b0, coord1_r};
  assign cin2 = {1'b0, low_r[2]} + {1'b0, coord2_r};
  assign osz0 = {1'b0, high_r[0]} - {1'b0, low_r[0]} + 13'd1;
  assign osz1 = {1'b0, high_r[1]} - {1'b0, low_r[1]} + 13'd1;
  assign ext1 = high_r[1] - low_r[1];
  assign ext2 = high_r[2] - low_r[2];
  assign last = (coord1_r == ext1) && (coord2_r == ext2);

  assign p_sum    = {1'b0, p1_r} + {14'd0, cin1};
  assign q_sum    = {1'b0, q1_r} + {15'd0, coord1_r};
  assign src_sum  = p2_r + {28'd0, low_r[0]};
  assign src_prod = src_sum * cfg.elem_bytes;
  assign dst_prod = q2_r * cfg.elem_bytes;
  assign len_prod = osz0 * cfg.elem_bytes;
  assign emit_ok  = cmd.emit && (cmd.emit_status == cla_pkg::STAT_OK);

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_cmd == cla_pkg::CMD_START) && (chk == cla_pkg::STAT_OK)) begin
      low_r    <= lo_m;
      high_r   <= hi_m;
      coord1_r <= '0;
      coord2_r <= '0;
    end else if (emit_ok && !last) begin
      if (coord1_r != ext1) begin
        coord1_r <= coord1_r + 12'd1;
      end else begin
        coord1_r <= '0;
        coord2_r <= coord2_r + 12'd1;
      end
    end
    if (cmd.mul1) begin
      p1_r <= cin2 * size_eff[1];
      q1_r <= coord2_r * osz1;
    end
    if (cmd.mul2) begin
      p2_r <= p_sum * size_eff[0];
      q2_r <= q_sum * osz0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.accept && (in_cmd == cla_pkg::CMD_START)) begin
      active_r <= (chk == cla_pkg::STAT_OK);
    end else if (emit_ok && last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      if (emit_ok) begin
        out_src_r  <= src_prod[39:0];
        out_dst_r  <= dst_prod[39:0];
        out_len_r  <= len_prod[16:0];
        out_last_r <= last;
      end else begin
        out_src_r  <= '0;
        out_dst_r  <= '0;
        out_len_r  <= '0;
        out_last_r <= 1'b0;
      end
    end
  end

  assign stat.active     = active_r;
  assign stat.chk_status = chk;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_src_offset = out_src_r;
  assign out_dst_offset = out_dst_r;
  assign out_line_bytes = out_len_r;
  assign out_last       = out_last_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && (cmd.emit_status != cla_pkg::STAT_OK) |=>
      (out_src_offset == '0) && (out_dst_offset == '0) &&
      (out_line_bytes == '0) && !out_last)
    else $error("error item carries nonzero fields");

  a_coord_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (coord1_r <= ext1) && (coord2_r <= ext2))
    else $error("odometer beyond crop box");

endmodule

`default_nettype wire

// ===== sv/crop_line_address_generator.sv =====
// Flow: after item accept, a scanline passes the two multiply stages, then scaling into
// the output register and out_valid; an error answer goes straight to the emit step.
// Items: in_ready is high only while the sequencer idles, so a new item waits until the
// last one is emitted, and a full output register holds the emit step.
// Reset: synchronous active-low rst_n; no crop active, registers num_dims 3,
// elem_bytes 1, all axis sizes 1.
`default_nettype none

module crop_line_address_generator #(
  parameter int MAX_DIMS      = 3,
  parameter int MAX_AXIS_SIZE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [11:0] in_lo0,
  input  wire logic [11:0] in_lo1,
  input  wire logic [11:0] in_lo2,
  input  wire logic [11:0] in_hi0,
  input  wire logic [11:0] in_hi1,
  input  wire logic [11:0] in_hi2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [39:0]      out_src_offset,
  output logic [39:0]      out_dst_offset,
  output logic [16:0]      out_line_bytes,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cla_pkg::cfg_t  cfg_r;
  cla_pkg::cmd_t  cmd;
  cla_pkg::stat_t stat;
  logic [cla_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_dims   <= 2'd3;
      cfg_r.elem_bytes <= 5'd1;
      cfg_r.size0      <= 13'd1;
      cfg_r.size1      <= 13'd1;
      cfg_r.size2      <= 13'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        cla_pkg::REG_NUM_DIMS:   cfg_r.num_dims   <= pwdata[1:0];
        cla_pkg::REG_ELEM_BYTES: cfg_r.elem_bytes <= pwdata[4:0];
        cla_pkg::REG_SIZE0:      cfg_r.size0      <= pwdata[12:0];
        cla_pkg::REG_SIZE1:      cfg_r.size1      <= pwdata[12:0];
        cla_pkg::REG_SIZE2:      cfg_r.size2      <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cla_pkg::REG_NUM_DIMS:   prdata = {30'd0, cfg_r.num_dims};
      cla_pkg::REG_ELEM_BYTES: prdata = {27'd0, cfg_r.elem_bytes};
      cla_pkg::REG_SIZE0:      prdata = {19'd0, cfg_r.size0};
      cla_pkg::REG_SIZE1:      prdata = {19'd0, cfg_r.size1};
      cla_pkg::REG_SIZE2:      prdata = {19'd0, cfg_r.size2};
      default:                 prdata = '0;
    endcase
  end

  cla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  cla_dp #(
    .MAX_DIMS      (MAX_DIMS),
    .MAX_AXIS_SIZE (MAX_AXIS_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_cmd         (in_cmd),
    .in_lo0         (in_lo0),
    .in_lo1         (in_lo1),
    .in_lo2         (in_lo2),
    .in_hi0         (in_hi0),
    .in_hi1         (in_hi1),
    .in_hi2         (in_hi2),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_line_bytes (out_line_bytes),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
